// File: sv/polyphase_rational_resampler_defines.svh
// Assertion macros for the polyphase rational resampler.
`ifndef POLYPHASE_RATIONAL_RESAMPLER_DEFINES_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PRR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("resampler check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("resampler check failed");

`endif

// File: sv/prr_pkg.sv
// Shared types and constants of the polyphase rational resampler.
package prr_pkg;

  localparam int DEF_MAX_PHASES = 256;
  localparam int DEF_MAX_HALF   = 64;
  localparam int DEF_CHANNELS   = 2;
  localparam int DEF_MAX_RUN    = 8;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int FACTOR_W = 9;
  localparam int HALF_W   = 7;
  localparam int CHAN_W   = 2;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERP = 2'd0,
    REG_DECIM  = 2'd1,
    REG_HALF   = 2'd2,
    REG_CHAN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_COEF    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_CHECK,
    S_TAPS,
    S_DRAIN,
    S_DIV,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic clr;
    logic issue;
    logic tap_en;
  } mac_ctrl_t;

endpackage

// File: sv/prr_coef_ram.sv
// Coefficient memory, one write and one registered read port.
module prr_coef_ram #(
  parameter int AW = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [prr_pkg::COEF_W-1:0] wdata_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic signed [prr_pkg::COEF_W-1:0] rdata_o
);
  import prr_pkg::*;

  logic signed [COEF_W-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/prr_hist_ram.sv
// Circular sample history with per-row valid bits and a registered read.
module prr_hist_ram #(
  parameter int ROWS = 129,
  parameter int CH   = 2,
  localparam int RW  = $clog2(ROWS)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   clr_i,
  input  logic                                   we_i,
  input  logic [RW-1:0]                          waddr_i,
  input  logic [CH-1:0][prr_pkg::SAMPLE_W-1:0]   wdata_i,
  input  logic [RW-1:0]                          raddr_i,
  output logic [CH-1:0][prr_pkg::SAMPLE_W-1:0]   rdata_o
);
  import prr_pkg::*;

  logic [CH-1:0][SAMPLE_W-1:0] mem_q [ROWS];
  logic [CH-1:0][SAMPLE_W-1:0] rd_q;
  logic [ROWS-1:0]             valid_q;
  logic                        hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      hit_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = hit_q ? rd_q : '0;

endmodule

// File: sv/prr_mac.sv
// Shared multiply-accumulate lanes with rounding and saturation.
module prr_mac #(
  parameter int CH   = 2,
  parameter int TAPS = 129
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  prr_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [prr_pkg::COEF_W-1:0]     coef_i,
  input  logic [CH-1:0][prr_pkg::SAMPLE_W-1:0]  samp_i,
  output logic [CH-1:0][prr_pkg::SAMPLE_W-1:0]  res_o,
  output logic                                  busy_o
);
  import prr_pkg::*;

  localparam int PRODW = SAMPLE_W + COEF_W;
  localparam int ACCW  = PRODW + $clog2(TAPS) + 1;
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(2**(SAMPLE_W-1) - 1);
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);
  localparam logic signed [ACCW-1:0] RND    = ACCW'(2**(COEF_W-3));

  logic v1_q, u1_q, v2_q;
  logic signed [PRODW-1:0] prod_q [CH];
  logic signed [ACCW-1:0]  acc_q [CH];
  logic signed [ACCW-1:0]  rnd [CH];
  logic signed [ACCW-1:0]  quo [CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      u1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      u1_q <= ctrl_i.tap_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CH; c++) begin
      if (v1_q) begin
        if (u1_q) begin
          prod_q[c] <= $signed(samp_i[c]) * coef_i;
        end else begin
          prod_q[c] <= '0;
        end
      end
      if (ctrl_i.clr) begin
        acc_q[c] <= '0;
      end else if (v2_q) begin
        acc_q[c] <= acc_q[c] + ACCW'(prod_q[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      rnd[c] = acc_q[c] + RND;
      quo[c] = rnd[c] >>> (COEF_W - 2);
      if (quo[c] > SAT_HI) begin
        res_o[c] = SAT_HI[SAMPLE_W-1:0];
      end else if (quo[c] < SAT_LO) begin
        res_o[c] = SAT_LO[SAMPLE_W-1:0];
      end else begin
        res_o[c] = quo[c][SAMPLE_W-1:0];
      end
    end
  end

  assign busy_o = v1_q | v2_q;

endmodule

// File: sv/prr_div.sv
// Restoring divider, one quotient bit per cycle.
module prr_div #(
  parameter int NW = 10,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? DW'(trial - {1'b0, divisor_i}) : DW'(trial);
        quo_q <= {quo_q[NW-2:0], fits};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/polyphase_rational_resampler.sv
// Two-channel rational L/M polyphase FIR resampler: top level and sequencer.
// A coefficient write, a restart or an ignored word leaves the sequencer idle.
// A sample frame is accepted and then, for each output it produces (at most
// MAX_RUN), passes a check, 2H+1 taps on the shared dual-lane multiply-
// accumulate unit, the pipeline drain, the phase divider and the hand-over of
// the word to the output register. A frame with no output due passes only the
// check, and a full output register adds its wait. When L equals M a frame
// passes straight through. The input side is not ready while a frame is in work.
// Coefficients sit in a memory indexed by phase and tap; the sample history is
// a circular memory whose per-row valid bits are cleared at once on reset and
// restart.
`include "polyphase_rational_resampler_defines.svh"

module polyphase_rational_resampler #(
  parameter int MAX_PHASES = prr_pkg::DEF_MAX_PHASES,
  parameter int MAX_HALF   = prr_pkg::DEF_MAX_HALF,
  parameter int CHANNELS   = prr_pkg::DEF_CHANNELS,
  parameter int MAX_RUN    = prr_pkg::DEF_MAX_RUN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prr_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [prr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // ch0_sample, ch1_sample, coef_phase, coef_index, coef_value
  input  logic [87:0]                    s_axis_tdata,
  // kind
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ch0_out, ch1_out
  output logic [47:0]                    m_axis_tdata,
  output logic                           m_axis_tlast
);
  import prr_pkg::*;

  localparam int STRIDE = 2 * MAX_HALF + 1;
  localparam int ROWW   = $clog2(STRIDE);
  localparam int TAPW   = ROWW;
  localparam int PW     = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int LW     = ($clog2(MAX_PHASES + 1) > FACTOR_W) ?
                          $clog2(MAX_PHASES + 1) : FACTOR_W;
  localparam int TW     = LW + 1;
  localparam int HW     = ($clog2(MAX_HALF + 1) > HALF_W) ? $clog2(MAX_HALF + 1) : HALF_W;
  localparam int RUNW   = $clog2(MAX_RUN + 1);

  seq_state_e state_q, state_d;

  logic [FACTOR_W-1:0] interp_q, decim_q;
  logic [HALF_W-1:0]   half_q;
  logic [CHAN_W-1:0]   chan_q;

  logic [31:0]     count_q, center_q, age_q;
  logic [PW-1:0]   phase_q;
  logic [ROWW-1:0] wp_q, wp_next, age_row, hist_raddr;
  logic [TAPW-1:0] tap_q, last_tap;
  logic [RUNW-1:0] n_q;
  logic [SAMPLE_W-1:0] pass0_q, pass1_q;

  logic                out_valid_q, out_last_q;
  logic [SAMPLE_W-1:0] out0_q, out1_q;

  logic [LW-1:0] l_eff;
  logic [HW-1:0] h_eff;
  logic          nch2, ident, due, run_last, out_free;
  logic [31:0]   lead;

  logic    accept, frame_acc, coef_acc, restart_acc;
  kind_e   kind;
  logic [SAMPLE_W-1:0] in_ch0, in_ch1;
  logic [7:0]          in_phase, in_index;
  logic [COEF_W-1:0]   in_coef;

  mac_ctrl_t mac_ctrl;
  logic      mac_busy, div_start, div_done, load_pass, load_run, coef_we;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] hist_wrow, hist_rrow, mac_res;
  logic signed [COEF_W-1:0] coef_rd;
  logic [TW-1:0] div_quot;
  logic [LW-1:0] div_rem;

  assign kind     = kind_e'(s_axis_tuser);
  assign in_ch0   = s_axis_tdata[23:0];
  assign in_ch1   = s_axis_tdata[47:24];
  assign in_phase = s_axis_tdata[55:48];
  assign in_index = s_axis_tdata[63:56];
  assign in_coef  = s_axis_tdata[87:64];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign frame_acc     = accept && (kind == KIND_FRAME);
  assign coef_acc      = accept && (kind == KIND_COEF);
  assign restart_acc   = accept && (kind == KIND_RESTART);

  always_comb begin
    if (interp_q == '0) begin
      l_eff = LW'(1);
    end else if (LW'(interp_q) > LW'(MAX_PHASES)) begin
      l_eff = LW'(MAX_PHASES);
    end else begin
      l_eff = LW'(interp_q);
    end
    if (half_q == '0) begin
      h_eff = HW'(1);
    end else if (HW'(half_q) > HW'(MAX_HALF)) begin
      h_eff = HW'(MAX_HALF);
    end else begin
      h_eff = HW'(half_q);
    end
  end

  assign nch2     = (CHANNELS > 1) && (chan_q != CHAN_W'(1));
  assign ident    = (l_eff == LW'(decim_q));
  assign last_tap = TAPW'({h_eff, 1'b0});
  assign lead     = count_q - center_q - 32'(h_eff);
  assign due      = (lead != '0) && !lead[31];
  assign run_last = !due || (n_q == RUNW'(MAX_RUN - 1));
  assign out_free = !out_valid_q || m_axis_tready;

  assign wp_next    = (wp_q == ROWW'(STRIDE - 1)) ? '0 : wp_q + ROWW'(1);
  assign age_row    = age_q[ROWW-1:0];
  assign hist_raddr = (wp_q >= age_row) ? wp_q - age_row : wp_q + ROWW'(STRIDE) - age_row;

  assign coef_we = coef_acc && (32'(in_phase) < 32'(MAX_PHASES)) &&
                   (32'(in_index) < 32'(STRIDE));

  always_comb begin
    hist_wrow = '0;
    hist_wrow[0] = in_ch0;
    if (CHANNELS > 1) begin
      hist_wrow[CHANNELS-1] = in_ch1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mac_ctrl  = '0;
    div_start = 1'b0;
    load_pass = 1'b0;
    load_run  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (frame_acc) begin
          state_d = ident ? S_PASS : S_CHECK;
        end
      end
      S_PASS: begin
        if (out_free) begin
          load_pass = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_CHECK: begin
        if (due && (n_q < RUNW'(MAX_RUN))) begin
          mac_ctrl.clr = 1'b1;
          state_d      = S_TAPS;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TAPS: begin
        mac_ctrl.issue  = 1'b1;
        mac_ctrl.tap_en = (age_q < 32'(STRIDE));
        if (tap_q == last_tap) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_run = 1'b1;
          state_d  = run_last ? S_IDLE : S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= FACTOR_W'(1);
      decim_q  <= FACTOR_W'(1);
      half_q   <= HALF_W'(8);
      chan_q   <= CHAN_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_INTERP: interp_q <= cfg_wdata_i;
        REG_DECIM:  decim_q  <= cfg_wdata_i;
        REG_HALF:   half_q   <= cfg_wdata_i[HALF_W-1:0];
        REG_CHAN:   chan_q   <= cfg_wdata_i[CHAN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      center_q <= '0;
      phase_q  <= '0;
      wp_q     <= '0;
      n_q      <= '0;
      tap_q    <= '0;
      age_q    <= '0;
    end else begin
      if (restart_acc) begin
        count_q  <= '0;
        center_q <= '0;
        phase_q  <= '0;
      end
      if (frame_acc) begin
        count_q <= count_q + 32'd1;
        wp_q    <= wp_next;
        n_q     <= '0;
        if (ident) begin
          center_q <= center_q + 32'd1;
        end
      end
      if (mac_ctrl.clr) begin
        tap_q <= '0;
        age_q <= lead - 32'd1 + 32'({h_eff, 1'b0});
      end else if (mac_ctrl.issue) begin
        tap_q <= tap_q + TAPW'(1);
        age_q <= age_q - 32'd1;
      end
      if (div_done) begin
        center_q <= center_q + 32'(div_quot);
        phase_q  <= div_rem[PW-1:0];
      end
      if (load_run) begin
        n_q <= n_q + RUNW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_acc) begin
      pass0_q <= in_ch0;
      pass1_q <= in_ch1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out0_q      <= '0;
      out1_q      <= '0;
    end else begin
      if (load_pass) begin
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
        out0_q      <= pass0_q;
        out1_q      <= nch2 ? pass1_q : '0;
      end else if (load_run) begin
        out_valid_q <= 1'b1;
        out_last_q  <= run_last;
        out0_q      <= mac_res[0];
        out1_q      <= nch2 ? mac_res[CHANNELS-1] : '0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out1_q, out0_q};
  assign m_axis_tlast  = out_last_q;

  prr_coef_ram #(
    .AW (PW + TAPW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i ({PW'(in_phase), TAPW'(in_index)}),
    .wdata_i ($signed(in_coef)),
    .raddr_i ({phase_q, tap_q}),
    .rdata_o (coef_rd)
  );

  prr_hist_ram #(
    .ROWS (STRIDE),
    .CH   (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (restart_acc),
    .we_i    (frame_acc),
    .waddr_i (wp_next),
    .wdata_i (hist_wrow),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rrow)
  );

  prr_mac #(
    .CH   (CHANNELS),
    .TAPS (STRIDE)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd),
    .samp_i (hist_rrow),
    .res_o  (mac_res),
    .busy_o (mac_busy)
  );

  prr_div #(
    .NW (TW),
    .DW (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (TW'(phase_q) + TW'(decim_q)),
    .divisor_i  (l_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  `PRR_ASSERT(a_tap_bound, state_q == S_TAPS, tap_q <= last_tap)
  `PRR_ASSERT(a_run_bound, state_q == S_EMIT, n_q < RUNW'(MAX_RUN))
  `PRR_ASSERT(a_div_after_drain, state_q == S_DIV, !mac_busy)
  `PRR_ASSERT_NEXT(a_frame_to_check, frame_acc && !ident, state_q == S_CHECK)

endmodule

// File: bench/tb.sv
// Self-checking bench for the two-channel polyphase rational resampler.
module tb;
  import prr_pkg::*;

  localparam int STRIDE = 2 * DEF_MAX_HALF + 1;
  localparam int SETTLE = 1300;
  localparam int LIMIT  = 3000000;

  typedef struct packed {
    logic [23:0] c0;
    logic [23:0] c1;
    logic        last;
  } out_word_t;

  typedef struct {
    kind_e       k;
    logic [23:0] a;
    logic [23:0] b;
    logic [7:0]  ph;
    logic [7:0]  ix;
    logic [23:0] v;
    int          nres;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  polyphase_rational_resampler uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  out_word_t   pending_q[$];
  int          errs = 0;
  int          cyc = 0;
  bit          smooth = 1'b0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int          hold_cnt = 0;
  out_word_t   head;

  int          coef_mem [STRIDE * DEF_MAX_PHASES];
  bit          coef_set [STRIDE * DEF_MAX_PHASES];
  int          hist [2][STRIDE];
  bit [31:0]   in_cnt, center;
  int          phase;
  int          r_l, r_m, r_h, r_ch;

  function automatic int eff_l();
    int l;
    l = r_l;
    if (l == 0) l = 1;
    if (l > DEF_MAX_PHASES) l = DEF_MAX_PHASES;
    return l;
  endfunction

  function automatic int eff_h();
    int h;
    h = r_h;
    if (h == 0) h = 1;
    if (h > DEF_MAX_HALF) h = DEF_MAX_HALF;
    return h;
  endfunction

  function automatic int round_sat(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< 21)) >>> 22;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return int'(q);
  endfunction

  function automatic void clear_run();
    for (int c = 0; c < 2; c++)
      for (int a = 0; a < STRIDE; a++) hist[c][a] = 0;
    in_cnt = '0;
    center = '0;
    phase = 0;
  endfunction

  function automatic void resample(kind_e k, logic [87:0] w, bit push);
    int        l, h, nch, len, n, res, ph, ix;
    bit [31:0] cnt_new, d;
    longint    acc, age, total;
    out_word_t run[$];
    out_word_t o;
    if (k == KIND_COEF) begin
      ph = w[55:48];
      ix = w[63:56];
      if (ix < STRIDE) begin
        coef_mem[ph * STRIDE + ix] = $signed(w[87:64]);
        coef_set[ph * STRIDE + ix] = 1'b1;
      end
      return;
    end
    if (k == KIND_RESTART) begin
      clear_run();
      return;
    end
    if (k != KIND_FRAME) return;
    for (int c = 0; c < 2; c++) begin
      for (int a = STRIDE - 1; a > 0; a--) hist[c][a] = hist[c][a-1];
      hist[c][0] = (c == 0) ? $signed(w[23:0]) : $signed(w[47:24]);
    end
    l = eff_l();
    h = eff_h();
    nch = (r_ch == 1) ? 1 : 2;
    len = 2 * h + 1;
    cnt_new = in_cnt + 1;
    if (l == r_m) begin
      o.c0 = hist[0][0][23:0];
      o.c1 = (nch > 1) ? hist[1][0][23:0] : 24'd0;
      o.last = 1'b1;
      if (push) pending_q.push_back(o);
      in_cnt = cnt_new;
      center = center + 1;
      return;
    end
    n = 0;
    while (n < DEF_MAX_RUN) begin
      d = cnt_new - center - h;
      if (d == 0 || d[31]) break;
      o = '0;
      for (int c = 0; c < nch; c++) begin
        acc = 0;
        for (int t = 0; t < len; t++) begin
          age = longint'({32'd0, d}) - 1 + 2 * h - t;
          if (age >= STRIDE || phase >= DEF_MAX_PHASES) continue;
          acc += longint'(hist[c][age]) * longint'(coef_mem[phase * STRIDE + t]);
        end
        res = round_sat(acc);
        if (c == 0) o.c0 = res[23:0];
        else o.c1 = res[23:0];
      end
      run.push_back(o);
      total = longint'(phase) + r_m;
      center = center + 32'(total / l);
      phase = int'(total % l);
      n++;
    end
    if (n > 0) run[n-1].last = 1'b1;
    if (push) foreach (run[i]) pending_q.push_back(run[i]);
    in_cnt = cnt_new;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (smooth || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(kind_e k, logic [87:0] w, bit push);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    resample(k, w, push);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val[8:0];
    @(posedge clk_i);
    case (idx)
      REG_INTERP: r_l = val & 9'h1ff;
      REG_DECIM:  r_m = val & 9'h1ff;
      REG_HALF:   r_h = val & 7'h7f;
      default:    r_ch = val & 2'h3;
    endcase
  endtask

  // Write every coefficient that the next frame's outputs will read and that is not yet set.
  task automatic fill_coefs();
    int        l, h, len, ph;
    bit [31:0] cnt_new, ctr, d;
    longint    total;
    l = eff_l();
    h = eff_h();
    if (l == r_m) return;
    len = 2 * h + 1;
    cnt_new = in_cnt + 1;
    ctr = center;
    ph = phase;
    for (int n = 0; n < DEF_MAX_RUN; n++) begin
      d = cnt_new - ctr - h;
      if (d == 0 || d[31]) break;
      for (int t = 0; t < len; t++)
        if (!coef_set[ph * STRIDE + t])
          send_word(KIND_COEF, {24'($urandom), 8'(t), 8'(ph), 48'd0}, 1'b1);
      total = longint'(ph) + r_m;
      ctr = ctr + 32'(total / l);
      ph = int'(total % l);
    end
  endtask

  function automatic logic [87:0] rand_frame();
    logic [23:0] a, b;
    int sel;
    a = 24'($urandom);
    b = 24'($urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) a = 24'h7fffff;
    if (sel == 1) a = 24'h800000;
    if (sel == 2) b = 24'h7fffff;
    if (sel == 3) b = 24'h800000;
    return {40'($urandom), b, a};
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78)
      send_word(KIND_FRAME, rand_frame(), 1'b1);
    else if (r < 90)
      send_word(KIND_COEF, {24'($urandom), 8'($urandom), 8'($urandom), 48'($urandom)}, 1'b1);
    else if (r < 95)
      send_word(KIND_RESTART, {88{1'b0}} | 88'($urandom), 1'b1);
    else
      send_word(KIND_NONE, {$urandom, $urandom, 24'($urandom)}, 1'b1);
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("output word with nothing expected");
        errs++;
      end else begin
        head = pending_q.pop_front();
        if (m_axis_tdata[23:0] !== head.c0) begin
          $error("ch0_out expected %h actual %h", head.c0, m_axis_tdata[23:0]);
          errs++;
        end
        if (m_axis_tdata[47:24] !== head.c1) begin
          $error("ch1_out expected %h actual %h", head.c1, m_axis_tdata[47:24]);
          errs++;
        end
        if (m_axis_tlast !== head.last) begin
          $error("last_of_run expected %b actual %b", head.last, m_axis_tlast);
          errs++;
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      hold_cnt <= 4000;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (smooth || $urandom_range(0, 99) < 60) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end
  end

  dir_row_t dir_tab [11];
  int       cfg_tab [7][4];
  logic [87:0] w;

  initial begin
    dir_tab = '{
      '{KIND_FRAME,   24'h7fffff, 24'h800000, 8'h00, 8'h00, 24'h000000, 1},
      '{KIND_FRAME,   24'h800000, 24'h7fffff, 8'h00, 8'h00, 24'h000000, 1},
      '{KIND_FRAME,   24'h000000, 24'hffffff, 8'h00, 8'h00, 24'h000000, 1},
      '{KIND_FRAME,   24'h000001, 24'h000000, 8'h00, 8'h00, 24'h000000, 1},
      '{KIND_NONE,    24'hffffff, 24'hffffff, 8'hff, 8'hff, 24'hffffff, 0},
      '{KIND_COEF,    24'h000000, 24'h000000, 8'hff, 8'h80, 24'h7fffff, 0},
      '{KIND_COEF,    24'h000000, 24'h000000, 8'h00, 8'h00, 24'h800000, 0},
      '{KIND_COEF,    24'h000000, 24'h000000, 8'h12, 8'hc8, 24'h123456, 0},
      '{KIND_RESTART, 24'h000000, 24'h000000, 8'h00, 8'h00, 24'h000000, 0},
      '{KIND_FRAME,   24'h555555, 24'haaaaaa, 8'h00, 8'h00, 24'h000000, 1},
      '{KIND_FRAME,   24'haaaaaa, 24'h555555, 8'h00, 8'h00, 24'h000000, 1}
    };
    cfg_tab = '{
      '{3, 2, 2, 2}, '{2, 3, 1, 1}, '{0, 0, 0, 3}, '{511, 511, 1, 2},
      '{2, 1, 127, 1}, '{5, 5, 4, 1}, '{1, 7, 3, 0}
    };
    foreach (coef_set[i]) begin
      coef_set[i] = 1'b0;
      coef_mem[i] = 0;
    end
    r_l = 1;
    r_m = 1;
    r_h = 8;
    r_ch = 2;
    clear_run();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      w = {dir_tab[i].v, dir_tab[i].ix, dir_tab[i].ph, dir_tab[i].b, dir_tab[i].a};
      if (dir_tab[i].nres > 0)
        pending_q.push_back('{dir_tab[i].a, dir_tab[i].b, 1'b1});
      send_word(dir_tab[i].k, w, 1'b0);
    end

    for (int s = 0; s < 7; s++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk_i);
      write_reg(REG_INTERP, cfg_tab[s][0]);
      write_reg(REG_DECIM, cfg_tab[s][1]);
      write_reg(REG_HALF, cfg_tab[s][2]);
      write_reg(REG_CHAN, cfg_tab[s][3]);
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      smooth = (s == 1);
      if (s == 0) stall_req = 1'b1;
      fill_coefs();
      for (int i = 0; i < 18; i++) begin
        if (i == 9) wait_drained();
        random_item();
        fill_coefs();
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (errs == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
